### src/jddm_pkg.sv
// Shared constants, types and helpers for the joystick differential drive mixer.
`default_nettype none

package jddm_pkg;

  // Packet admission
  localparam logic [7:0] GOOD_LENGTH  = 8'd12;
  localparam logic [7:0] GOOD_VERSION = 8'd2;

  // Joystick dead zone and span
  localparam int DZ_LOW    = 1800;
  localparam int DZ_HIGH   = 2200;
  localparam int AXIS_SPAN = 1200;

  // Datapath widths
  localparam int AXIS_W = 12;
  localparam int MAG_W  = 12;
  localparam int MM_W   = 15;
  localparam int PROD_W = MAG_W + MM_W;
  localparam int Q_W    = 17;
  localparam int SPD_W  = 16;

  // Reciprocal of AXIS_SPAN: exact floor division for any PROD_W-bit numerator
  localparam int          DIV_SHIFT  = PROD_W + 11;
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << DIV_SHIFT) + 64'(AXIS_SPAN - 1)) / 64'(AXIS_SPAN);
  localparam int          RECIP_W    = PROD_W + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_WIDE[RECIP_W-1:0];
  localparam int          DIV_W      = PROD_W + RECIP_W;

  // Reset values of the configuration registers
  localparam logic [14:0] MAX_MANUAL_RST = 15'd100;
  localparam logic [14:0] MAX_SPEED_RST  = 15'd100;
  localparam logic [15:0] TIMEOUT_RST    = 16'd1000;

  typedef enum logic [1:0] {
    CFG_MAX_MANUAL = 2'd0,
    CFG_MAX_SPEED  = 2'd1,
    CFG_TIMEOUT    = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED    = 2'd0,
    ST_BAD_LENGTH  = 2'd1,
    ST_BAD_VERSION = 2'd2,
    ST_TICK        = 2'd3
  } status_t;

  // Dead-zone map of one raw axis sample to a signed offset of at most AXIS_SPAN
  function automatic logic signed [AXIS_W-1:0] axis_offset(input logic [AXIS_W-1:0] raw);
    logic [AXIS_W-1:0]        d;
    logic signed [AXIS_W-1:0] off;
    d   = '0;
    off = '0;
    if (raw < AXIS_W'(DZ_LOW)) begin
      d = AXIS_W'(DZ_LOW) - raw;
      if (d > AXIS_W'(AXIS_SPAN)) d = AXIS_W'(AXIS_SPAN);
      off = -$signed(d);
    end else if (raw > AXIS_W'(DZ_HIGH)) begin
      d = raw - AXIS_W'(DZ_HIGH);
      if (d > AXIS_W'(AXIS_SPAN)) d = AXIS_W'(AXIS_SPAN);
      off = $signed(d);
    end
    return off;
  endfunction

endpackage

`default_nettype wire

### src/joystick_differential_drive_mixer_core.sv
// Top level: packet check, dead-zone mixing pipeline and link supervision state.
`default_nettype none

// Accepts one beat per cycle (a received packet or a millisecond tick) and returns
// one result beat for each, in order, after it passes through an input register, a
// register after the axis-by-scale multiply, a register after the reciprocal multiply
// that divides by the axis span, and the supervision state, which doubles as the result
// register. Throughput is one beat per clock; a stalled output backs up through the four
// stages, and each stage keeps taking beats while it has room. Configuration writes take
// effect at once and belong only to times when no beat is in flight.
module joystick_differential_drive_mixer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_op,
  input  wire logic [7:0]  in_packet_length,
  input  wire logic [7:0]  in_version,
  input  wire logic [15:0] in_battery_mv,
  input  wire logic [7:0]  in_drive_mode,
  input  wire logic [11:0] in_x_raw,
  input  wire logic [11:0] in_y_raw,
  // result channel
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [1:0]         out_status,
  output logic signed [15:0] out_speed_left,
  output logic signed [15:0] out_speed_right,
  output logic               out_link_valid,
  output logic [15:0]        out_battery_out,
  output logic [7:0]         out_mode_out,
  output logic [31:0]        out_packet_count
);

  localparam int AxisW = jddm_pkg::AXIS_W;
  localparam int MagW  = jddm_pkg::MAG_W;
  localparam int ProdW = jddm_pkg::PROD_W;
  localparam int QW    = jddm_pkg::Q_W;
  localparam int DivW  = jddm_pkg::DIV_W;
  localparam int SpdW  = jddm_pkg::SPD_W;

  // ---------------- configuration ----------------
  logic [14:0] max_manual_r;
  logic [14:0] max_speed_r;
  logic [15:0] timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_manual_r <= jddm_pkg::MAX_MANUAL_RST;
      max_speed_r  <= jddm_pkg::MAX_SPEED_RST;
      timeout_r    <= jddm_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        jddm_pkg::CFG_MAX_MANUAL: max_manual_r <= cfg_wdata[14:0];
        jddm_pkg::CFG_MAX_SPEED:  max_speed_r  <= cfg_wdata[14:0];
        jddm_pkg::CFG_TIMEOUT:    timeout_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic v0_r, v1_r, v2_r, out_valid_r;
  logic out_free, s2_free, s1_free, s0_free, retire;

  assign out_free = !out_valid_r || out_ready;
  assign s2_free  = !v2_r || out_free;
  assign s1_free  = !v1_r || s2_free;
  assign s0_free  = !v0_r || s1_free;
  assign retire   = v2_r && out_free;
  assign in_ready = s0_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s0_free)  v0_r        <= in_valid;
      if (s1_free)  v1_r        <= v0_r;
      if (s2_free)  v2_r        <= v1_r;
      if (out_free) out_valid_r <= v2_r;
    end
  end

  // ---------------- stage 0: input register ----------------
  logic             op0_r;
  logic [7:0]       len0_r, ver0_r, mode0_r;
  logic [15:0]      bat0_r;
  logic [AxisW-1:0] x0_r, y0_r;

  always_ff @(posedge clk) begin
    if (s0_free) begin
      op0_r   <= in_op;
      len0_r  <= in_packet_length;
      ver0_r  <= in_version;
      bat0_r  <= in_battery_mv;
      mode0_r <= in_drive_mode;
      x0_r    <= in_x_raw;
      y0_r    <= in_y_raw;
    end
  end

  jddm_pkg::status_t        st0;
  logic signed [AxisW-1:0]  ox0, oy0;
  logic signed [AxisW:0]    lsum0, rsum0;
  logic [MagW-1:0]          lmag0, rmag0;

  always_comb begin
    if (op0_r)                            st0 = jddm_pkg::ST_TICK;
    else if (len0_r != jddm_pkg::GOOD_LENGTH)  st0 = jddm_pkg::ST_BAD_LENGTH;
    else if (ver0_r != jddm_pkg::GOOD_VERSION) st0 = jddm_pkg::ST_BAD_VERSION;
    else                                  st0 = jddm_pkg::ST_ACCEPTED;
  end

  assign ox0   = jddm_pkg::axis_offset(x0_r);
  assign oy0   = jddm_pkg::axis_offset(y0_r);
  assign lsum0 = (AxisW+1)'(oy0) - (AxisW+1)'(ox0);
  assign rsum0 = (AxisW+1)'(oy0) + (AxisW+1)'(ox0);
  assign lmag0 = lsum0[AxisW] ? MagW'(-lsum0) : MagW'(lsum0);
  assign rmag0 = rsum0[AxisW] ? MagW'(-rsum0) : MagW'(rsum0);

  // ---------------- stage 1: magnitude times scale ----------------
  jddm_pkg::status_t st1_r;
  logic [15:0]       bat1_r;
  logic [7:0]        mode1_r;
  logic [ProdW-1:0]  lprod1_r, rprod1_r;
  logic              lneg1_r, rneg1_r;

  always_ff @(posedge clk) begin
    if (s1_free) begin
      st1_r    <= st0;
      bat1_r   <= bat0_r;
      mode1_r  <= mode0_r;
      lprod1_r <= ProdW'(lmag0) * ProdW'(max_manual_r);
      rprod1_r <= ProdW'(rmag0) * ProdW'(max_manual_r);
      lneg1_r  <= lsum0[AxisW];
      rneg1_r  <= rsum0[AxisW];
    end
  end

  // round half away: floor((mag + span/2) / span) through the exact reciprocal
  logic [ProdW-1:0] lnum1, rnum1;
  logic [DivW-1:0]  ldiv1, rdiv1;

  assign lnum1 = lprod1_r + ProdW'(jddm_pkg::AXIS_SPAN / 2);
  assign rnum1 = rprod1_r + ProdW'(jddm_pkg::AXIS_SPAN / 2);
  assign ldiv1 = DivW'(lnum1) * DivW'(jddm_pkg::RECIP);
  assign rdiv1 = DivW'(rnum1) * DivW'(jddm_pkg::RECIP);

  // ---------------- stage 2: quotient ----------------
  jddm_pkg::status_t st2_r;
  logic [15:0]       bat2_r;
  logic [7:0]        mode2_r;
  logic [QW-1:0]     lq2_r, rq2_r;
  logic              lneg2_r, rneg2_r;

  always_ff @(posedge clk) begin
    if (s2_free) begin
      st2_r   <= st1_r;
      bat2_r  <= bat1_r;
      mode2_r <= mode1_r;
      lq2_r   <= ldiv1[jddm_pkg::DIV_SHIFT +: QW];
      rq2_r   <= rdiv1[jddm_pkg::DIV_SHIFT +: QW];
      lneg2_r <= lneg1_r;
      rneg2_r <= rneg1_r;
    end
  end

  logic [14:0]            lclamp2, rclamp2;
  logic signed [SpdW-1:0] lspd2, rspd2;

  assign lclamp2 = (lq2_r > QW'(max_speed_r)) ? max_speed_r : lq2_r[14:0];
  assign rclamp2 = (rq2_r > QW'(max_speed_r)) ? max_speed_r : rq2_r[14:0];
  assign lspd2   = lneg2_r ? -$signed({1'b0, lclamp2}) : $signed({1'b0, lclamp2});
  assign rspd2   = rneg2_r ? -$signed({1'b0, rclamp2}) : $signed({1'b0, rclamp2});

  // ---------------- supervision state / result register ----------------
  jddm_pkg::status_t      status_r;
  logic [31:0]            count_r, count_nxt;
  logic [15:0]            age_r, age_nxt, age_inc;
  logic                   link_r, link_nxt;
  logic [15:0]            bat_r, bat_nxt;
  logic [7:0]             mode_r, mode_nxt;
  logic signed [SpdW-1:0] left_r, left_nxt, right_r, right_nxt;

  assign age_inc = (age_r == 16'hFFFF) ? age_r : age_r + 16'd1;

  always_comb begin
    count_nxt = count_r;
    age_nxt   = age_r;
    link_nxt  = link_r;
    bat_nxt   = bat_r;
    mode_nxt  = mode_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    case (st2_r)
      jddm_pkg::ST_TICK: begin
        age_nxt = age_inc;
        // drop the link once the age passes the timeout
        if (link_r && (age_inc > timeout_r)) link_nxt = 1'b0;
      end
      jddm_pkg::ST_ACCEPTED: begin
        count_nxt = count_r + 32'd1;
        age_nxt   = '0;
        link_nxt  = 1'b1;
        bat_nxt   = bat2_r;
        mode_nxt  = mode2_r;
        left_nxt  = lspd2;
        right_nxt = rspd2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      age_r    <= '0;
      link_r   <= 1'b0;
      bat_r    <= '0;
      mode_r   <= '0;
      left_r   <= '0;
      right_r  <= '0;
      status_r <= jddm_pkg::ST_ACCEPTED;
    end else if (retire) begin
      count_r  <= count_nxt;
      age_r    <= age_nxt;
      link_r   <= link_nxt;
      bat_r    <= bat_nxt;
      mode_r   <= mode_nxt;
      left_r   <= left_nxt;
      right_r  <= right_nxt;
      status_r <= st2_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_speed_left   = left_r;
  assign out_speed_right  = right_r;
  assign out_link_valid   = link_r;
  assign out_battery_out  = bat_r;
  assign out_mode_out     = mode_r;
  assign out_packet_count = count_r;

`ifndef NO_ASSERTIONS
  a_reject_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (retire && (st2_r == jddm_pkg::ST_BAD_LENGTH || st2_r == jddm_pkg::ST_BAD_VERSION))
    |=> $stable(count_r) && $stable(left_r) && $stable(link_r))
    else $error("rejected packet changed supervision state");

  a_accept_sets_link: assert property (@(posedge clk) disable iff (!rst_n)
    (retire && st2_r == jddm_pkg::ST_ACCEPTED)
    |=> link_r && (age_r == 16'd0) && (count_r == $past(count_r) + 32'd1))
    else $error("accepted packet did not refresh link");

  a_age_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (retire && st2_r == jddm_pkg::ST_TICK && age_r == 16'hFFFF) |=> (age_r == 16'hFFFF))
    else $error("age counter wrapped");
`endif

endmodule

`default_nettype wire
